>>> hdl/jspc_pkg.sv
// Shared types and constants for the Julia-set pixel colorizer.
// Depends on nothing; used by the front end, the item queue and the iteration engine.
package jspc_pkg;

    localparam int FRAC_BITS = 28;
    localparam int STEP_W    = 31;
    localparam int C_W       = 32;
    localparam int PIX_W     = 10;
    localparam int COUNT_W   = 9;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Start points inside +/-4.0 fit here; anything outside escapes at once.
    localparam int ZW = FRAC_BITS + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPAN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG    = 3'd4;

    typedef struct packed {
        logic                 far;
        logic signed [ZW-1:0] z_re;
        logic signed [ZW-1:0] z_im;
    } item_t;

endpackage

>>> hdl/julia_set_pixel_colorizer.sv
// Top level of the Julia-set pixel colorizer: configuration registers and the
// front end / queue / iteration engine chain. Depends on jspc_pkg and all jspc_ modules.
//
// Usage:
//   Pixel items enter on start/pixel_x/pixel_y and are taken at an edge where
//   start is high and busy is low. busy rises for the cycle after each take
//   and stays up while the front end cannot place its item in the queue.
//   Each item gives one result: done is high for exactly one cycle with
//   escape_count, red, green and blue valid; the receiver cannot hold it off.
//   Results come out in the order items went in.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Indexes 0..4 are x_step, y_step, half_span, c_real,
//   c_imag; other indexes are dropped. Write only while no item is in flight.
// Sequencing:
//   The front end does the step multiply, then maps and pushes; a full queue
//   holds the push, and no new pixel is taken until it is done. The engine
//   loads an item, then per iteration multiplies, then updates and tests, for
//   up to MAX_ITERATIONS+1 iterations, and registers the result at the end.
//   Start points beyond +/-4.0 in either axis finish at load, with no iteration.
//   Reset loads the default view and Julia constant and empties the queue.
module julia_set_pixel_colorizer #(
    parameter int MAX_ITERATIONS = 512
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [jspc_pkg::PIX_W-1:0]          pixel_x,
    input  logic [jspc_pkg::PIX_W-1:0]          pixel_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jspc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                done,
    output logic [jspc_pkg::COUNT_W-1:0]        escape_count,
    output logic [jspc_pkg::COLOR_W-1:0]        red,
    output logic [jspc_pkg::COLOR_W-1:0]        green,
    output logic [jspc_pkg::COLOR_W-1:0]        blue
);

    localparam int QUEUE_DEPTH = 2;

    logic [jspc_pkg::STEP_W-1:0]      x_step_reg;
    logic [jspc_pkg::STEP_W-1:0]      y_step_reg;
    logic [jspc_pkg::STEP_W-1:0]      half_span_reg;
    logic signed [jspc_pkg::C_W-1:0]  c_real_reg;
    logic signed [jspc_pkg::C_W-1:0]  c_imag_reg;

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    jspc_pkg::item_t q_in;
    jspc_pkg::item_t q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg    <= 31'd1272950;
            y_step_reg    <= 31'd1272950;
            half_span_reg <= 31'd382520525;
            c_real_reg    <= -32'sd146076132;
            c_imag_reg    <= -32'sd141587355;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                jspc_pkg::CFG_X_STEP:    x_step_reg    <= cfg_data[jspc_pkg::STEP_W-1:0];
                jspc_pkg::CFG_Y_STEP:    y_step_reg    <= cfg_data[jspc_pkg::STEP_W-1:0];
                jspc_pkg::CFG_HALF_SPAN: half_span_reg <= cfg_data[jspc_pkg::STEP_W-1:0];
                jspc_pkg::CFG_C_REAL:    c_real_reg    <= $signed(cfg_data);
                jspc_pkg::CFG_C_IMAG:    c_imag_reg    <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    jspc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .x_step    (x_step_reg),
        .y_step    (y_step_reg),
        .half_span (half_span_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    jspc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .item_out (q_out)
    );

    jspc_engine #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (q_out),
        .q_pop        (q_pop),
        .c_real       (c_real_reg),
        .c_imag       (c_imag_reg),
        .done         (done),
        .escape_count (escape_count),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

endmodule

>>> hdl/jspc_front.sv
// Front end: takes a pixel, maps it to its start point and classifies it.
// Depends on jspc_pkg; feeds jspc_fifo.
module jspc_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [jspc_pkg::PIX_W-1:0]          pixel_x,
    input  logic [jspc_pkg::PIX_W-1:0]          pixel_y,
    input  logic [jspc_pkg::STEP_W-1:0]         x_step,
    input  logic [jspc_pkg::STEP_W-1:0]         y_step,
    input  logic [jspc_pkg::STEP_W-1:0]         half_span,
    input  logic                                q_full,
    output logic                                q_push,
    output jspc_pkg::item_t                     q_item
);

    localparam int MW  = jspc_pkg::STEP_W + jspc_pkg::PIX_W;
    localparam int SPW = MW + 1;
    localparam int ZW  = jspc_pkg::ZW;

    logic              hold_reg;
    logic [MW-1:0]     xprod_reg;
    logic [MW-1:0]     yprod_reg;
    logic signed [SPW-1:0] sx;
    logic signed [SPW-1:0] sy;
    logic              far_x;
    logic              far_y;

    assign busy   = hold_reg;
    assign q_push = hold_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (start && !hold_reg)
        begin
            hold_reg <= 1'b1;
        end
        else if (q_push)
        begin
            hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !hold_reg)
        begin
            xprod_reg <= MW'(x_step) * MW'(pixel_x);
            yprod_reg <= MW'(y_step) * MW'(pixel_y);
        end
    end

    always_comb
    begin
        sx = $signed({1'b0, xprod_reg}) - $signed(SPW'(half_span));
        sy = $signed({1'b0, yprod_reg}) - $signed(SPW'(half_span));
        // outside +/-4.0 the first squaring lands beyond the escape box
        far_x = sx[SPW-1:ZW-1] != {(SPW - ZW + 1){sx[ZW-1]}};
        far_y = sy[SPW-1:ZW-1] != {(SPW - ZW + 1){sy[ZW-1]}};
        q_item.far  = far_x || far_y;
        q_item.z_re = $signed(sx[ZW-1:0]);
        q_item.z_im = $signed(sy[ZW-1:0]);
    end

endmodule

>>> hdl/jspc_fifo.sv
// Short item queue between the front end and the iteration engine.
// Depends on jspc_pkg for the item type.
module jspc_fifo #(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jspc_pkg::item_t item_in,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output jspc_pkg::item_t item_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    jspc_pkg::item_t slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   count_reg;

    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign item_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> hdl/jspc_engine.sv
// Iteration engine: runs z = z*z + c on one queued item, then colors the escape count.
// Depends on jspc_pkg; takes items from jspc_fifo.
module jspc_engine #(
    parameter int MAX_ITERATIONS = 512
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  jspc_pkg::item_t                    q_item,
    output logic                               q_pop,
    input  logic signed [jspc_pkg::C_W-1:0]    c_real,
    input  logic signed [jspc_pkg::C_W-1:0]    c_imag,
    output logic                               done,
    output logic [jspc_pkg::COUNT_W-1:0]       escape_count,
    output logic [jspc_pkg::COLOR_W-1:0]       red,
    output logic [jspc_pkg::COLOR_W-1:0]       green,
    output logic [jspc_pkg::COLOR_W-1:0]       blue
);

    localparam int CW = $clog2(MAX_ITERATIONS + 1);
    localparam int ZW = jspc_pkg::ZW;
    localparam int F  = jspc_pkg::FRAC_BITS;
    localparam int PW = 2 * ZW;
    localparam int SW = PW - F + 3;

    localparam logic [CW-1:0] LAST_IT  = CW'(MAX_ITERATIONS);
    localparam logic [CW-1:0] HALF_IT  = CW'(MAX_ITERATIONS / 2);
    localparam logic signed [SW-1:0] LIM_HI = $signed((SW'(1) << (F + 1)) - SW'(1));
    localparam logic signed [SW-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [SW-1:0] THREE  = $signed(SW'(3) << F);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        iter_reg, iter_next;
    logic signed [ZW-1:0] zr_reg, zr_next;
    logic signed [ZW-1:0] zi_reg, zi_next;
    logic signed [PW-1:0] prr_reg;
    logic signed [PW-1:0] pii_reg;
    logic signed [PW-1:0] pri_reg;

    logic                                done_reg;
    logic [jspc_pkg::COUNT_W-1:0]        count_reg;
    logic [jspc_pkg::COLOR_W-1:0]        red_reg;
    logic [jspc_pkg::COLOR_W-1:0]        green_reg;
    logic [jspc_pkg::COLOR_W-1:0]        blue_reg;

    logic signed [SW-1:0] rr, ii, ri, nr, ni, mag;
    logic                 out_box;
    logic                 finish;
    logic [CW-1:0]        fin_count;

    logic [15:0]          cnt16;
    logic [8:0]           fold;
    logic [7:0]           n_mod;
    logic [jspc_pkg::COLOR_W-1:0] red_c, green_c, blue_c;

    assign done         = done_reg;
    assign escape_count = count_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;

    // floor-shifted products and the candidate next z
    always_comb
    begin
        rr  = SW'(prr_reg >>> F);
        ii  = SW'(pii_reg >>> F);
        ri  = SW'(pri_reg >>> F);
        nr  = rr - ii + SW'(c_real);
        ni  = (ri <<< 1) + SW'(c_imag);
        mag = rr + ii;
        out_box = (nr > LIM_HI) || (nr < LIM_LO) || (ni > LIM_HI) || (ni < LIM_LO);
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        finish     = 1'b0;
        fin_count  = '0;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.far)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        zr_next    = q_item.z_re;
                        zi_next    = q_item.z_im;
                        iter_next  = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // |z|^2 of the z kept last round equals this round's squares
                priority if (iter_reg != '0 && mag > THREE)
                begin
                    finish     = 1'b1;
                    fin_count  = iter_reg - CW'(1);
                    state_next = ST_IDLE;
                end
                else if (iter_reg == LAST_IT)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_box)
                begin
                    finish     = 1'b1;
                    fin_count  = iter_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    zr_next    = $signed(nr[ZW-1:0]);
                    zi_next    = $signed(ni[ZW-1:0]);
                    iter_next  = iter_reg + CW'(1);
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // count mod 255: 256 = 1 (mod 255), so fold the two bytes and correct once
    always_comb
    begin
        cnt16 = 16'(fin_count);
        fold  = {1'b0, cnt16[15:8]} + {1'b0, cnt16[7:0]};
        n_mod = (fold >= 9'd255) ? 8'(fold - 9'd255) : fold[7:0];
        if (fin_count == '0)
        begin
            red_c   = '0;
            green_c = '0;
            blue_c  = '0;
        end
        else if (fin_count < HALF_IT)
        begin
            red_c   = {n_mod[5:0], 2'b00};
            green_c = {n_mod[4:0], 3'b000};
            blue_c  = {n_mod[3:0], 4'b0000};
        end
        else
        begin
            red_c   = {n_mod[3:0], 4'b0000};
            green_c = {n_mod[5:0], 2'b00};
            blue_c  = {n_mod[2:0], 5'b00000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg <= iter_next;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        if (state_reg == ST_MUL)
        begin
            prr_reg <= PW'(zr_reg) * PW'(zr_reg);
            pii_reg <= PW'(zi_reg) * PW'(zi_reg);
            pri_reg <= PW'(zr_reg) * PW'(zi_reg);
        end
        if (finish)
        begin
            count_reg <= cnt16[jspc_pkg::COUNT_W-1:0];
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
        end
    end

endmodule
